// ----- design/cht_pkg.sv -----
// cht_pkg: constants, opcode and status codes for the chained hash table.
// No dependencies.
`default_nettype none
package cht_pkg;
  localparam int BUCKETS    = 64;
  localparam int ENTRIES    = 128;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int BKT_W = $clog2(BUCKETS);
  localparam int PTR_W = $clog2(ENTRIES) + 1;   // extra code for null
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [PTR_W-1:0] NIL = PTR_W'(ENTRIES);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_ERASE  = 2'd2,
    OP_UNUSED = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_NEW     = 3'd0,
    ST_UPDATED = 3'd1,
    ST_FOUND   = 3'd2,
    ST_MISSING = 3'd3,
    ST_ERASED  = 3'd4,
    ST_FULL    = 3'd5
  } status_t;
endpackage
`default_nettype wire

// ----- design/cht_node_ram.sv -----
// cht_node_ram: node key, value and link stores, one write port each and a shared registered read port.
// Depends on cht_pkg. Links reset as a free list via a fill mark.
`default_nettype none
module cht_node_ram (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [cht_pkg::IDX_W-1:0]    rd_addr,
  input  wire logic                         kv_we,
  input  wire logic [cht_pkg::IDX_W-1:0]    kv_addr,
  input  wire logic [cht_pkg::KEY_BITS-1:0] kv_key,
  input  wire logic [cht_pkg::VALUE_BITS-1:0] kv_value,
  input  wire logic                         v_we,
  input  wire logic                         ln_we,
  input  wire logic [cht_pkg::IDX_W-1:0]    ln_addr,
  input  wire logic [cht_pkg::PTR_W-1:0]    ln_data,
  output logic [cht_pkg::KEY_BITS-1:0]      rd_key,
  output logic [cht_pkg::VALUE_BITS-1:0]    rd_value,
  output logic [cht_pkg::PTR_W-1:0]         rd_link
);
  import cht_pkg::*;
  logic [KEY_BITS-1:0]   key_mem  [ENTRIES];
  logic [VALUE_BITS-1:0] val_mem  [ENTRIES];
  logic [PTR_W-1:0]      link_mem [ENTRIES];
  // links at or above the high-water mark read as index+1; touched is that high-water
  // mark: free list pops in index order from the untouched region
  logic [CNT_W-1:0] touched;
  logic [PTR_W-1:0] link_q;
  logic             fresh_q;
  logic [IDX_W-1:0] addr_q;

  always_ff @(posedge clk) begin
    if (kv_we) key_mem[kv_addr] <= kv_key;
    if (kv_we || v_we) val_mem[kv_addr] <= kv_value;
    if (ln_we) link_mem[ln_addr] <= ln_data;
    rd_key   <= key_mem[rd_addr];
    rd_value <= val_mem[rd_addr];
    link_q   <= link_mem[rd_addr];
    fresh_q  <= CNT_W'(rd_addr) >= touched;
    addr_q   <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      touched <= '0;
    end else if (ln_we && CNT_W'(ln_addr) >= touched) begin
      touched <= CNT_W'(ln_addr) + CNT_W'(1);
    end
  end

  assign rd_link = fresh_q ? PTR_W'(addr_q) + PTR_W'(1) : link_q;
endmodule
`default_nettype wire

// ----- design/cht_ctrl.sv -----
// cht_ctrl: sequencer walking one chain node per S_READ/S_CMP pair, then updating.
// Depends on cht_pkg and cht_node_ram.
`default_nettype none
module cht_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           go,
  input  wire logic [1:0]                     opcode,
  input  wire logic [cht_pkg::KEY_BITS-1:0]   key,
  input  wire logic [cht_pkg::VALUE_BITS-1:0] value,
  output logic                                busy,
  output logic                                done,
  output logic [2:0]                          status,
  output logic [cht_pkg::VALUE_BITS-1:0]      found_value,
  output logic [cht_pkg::CNT_W-1:0]           count
);
  import cht_pkg::*;
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_HEAD = 6'b000010, S_READ = 6'b000100,
    S_CMP  = 6'b001000, S_FREE = 6'b010000, S_DONE = 6'b100000
  } state_t;
  state_t state;
  logic [1:0]            op;
  logic [KEY_BITS-1:0]   k;
  logic [VALUE_BITS-1:0] v;
  logic [BKT_W-1:0]      bkt;
  logic [PTR_W-1:0]      cur, prev, free_head;
  logic [CNT_W-1:0]      steps;
  logic [PTR_W-1:0]      head_mem [BUCKETS];
  logic [BUCKETS-1:0]    head_ok;
  logic [PTR_W-1:0]      head_q;
  logic                  head_we;
  logic [PTR_W-1:0]      head_d;

  logic [IDX_W-1:0]      rd_addr, kv_addr, ln_addr;
  logic                  kv_we, v_we, ln_we;
  logic [PTR_W-1:0]      ln_data;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_value;
  logic [PTR_W-1:0]      rd_link;

  // shared link write port: S_DONE slot carries the deferred write
  logic              lw_en;
  logic [IDX_W-1:0]  lw_addr;
  logic [PTR_W-1:0]  lw_data;

  cht_node_ram u_ram (
    .clk, .rst, .rd_addr, .kv_we, .kv_addr, .kv_key(k), .kv_value(v),
    .v_we, .ln_we(lw_en), .ln_addr(lw_addr), .ln_data(lw_data),
    .rd_key, .rd_value, .rd_link
  );

  always_ff @(posedge clk) begin
    if (head_we) head_mem[bkt] <= head_d;
    head_q <= head_mem[BKT_W'(key)];
  end

  logic hit, at_end;
  // a null pointer still reads node zero, so a key match only counts on a real node
  assign hit    = cur != NIL && rd_key == k;
  assign at_end = cur == NIL || steps == CNT_W'(ENTRIES);

  always_comb begin
    rd_addr = cur[IDX_W-1:0];
    if (state == S_CMP && hit && op == OP_ERASE) rd_addr = free_head[IDX_W-1:0];
    if (state == S_CMP && !hit && op == OP_INSERT) rd_addr = free_head[IDX_W-1:0];
    kv_we = 1'b0; v_we = 1'b0; ln_we = 1'b0; head_we = 1'b0;
    kv_addr = cur[IDX_W-1:0]; ln_addr = prev[IDX_W-1:0];
    ln_data = NIL; head_d = NIL;
    if (state == S_CMP && !at_end && hit) begin
      if (op == OP_INSERT) v_we = 1'b1;
      if (op == OP_ERASE) begin
        head_d = rd_link; ln_data = rd_link;
        if (prev == NIL) head_we = 1'b1; else ln_we = 1'b1;
      end
    end
    if (state == S_FREE) begin
      // new node: key/value and hook to tail now; its null link follows in S_DONE
      kv_we = 1'b1; kv_addr = free_head[IDX_W-1:0];
      head_d = free_head; ln_data = free_head;
      if (prev == NIL) head_we = 1'b1; else ln_we = 1'b1;
    end
  end

  // second link write (new node null link / erased node to free list)
  logic              ln2_pend;
  logic [IDX_W-1:0]  ln2_addr;
  logic [PTR_W-1:0]  ln2_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; head_ok <= '0; free_head <= '0; count <= '0; done <= 1'b0;
      ln2_pend <= 1'b0;
    end else begin
      done <= 1'b0;
      if (head_we) head_ok[bkt] <= 1'b1;
      case (state)
        S_IDLE: if (go) begin
          op <= opcode; k <= key; v <= value; bkt <= BKT_W'(key);
          prev <= NIL; steps <= '0; found_value <= '0; state <= S_HEAD;
        end
        S_HEAD: begin
          cur <= head_ok[bkt] ? head_q : NIL;
          state <= S_READ;
        end
        S_READ: state <= S_CMP;
        S_CMP: begin
          if (at_end || !hit) begin
            if (!at_end) begin
              prev <= cur; cur <= rd_link; steps <= steps + CNT_W'(1); state <= S_READ;
            end else if (op == OP_INSERT) begin
              if (free_head == NIL) begin
                status <= ST_FULL; state <= S_DONE;
              end else state <= S_FREE;
            end else begin
              status <= ST_MISSING; state <= S_DONE;
            end
          end else begin
            case (op)
              OP_INSERT: status <= ST_UPDATED;
              OP_FIND: begin status <= ST_FOUND; found_value <= rd_value; end
              OP_ERASE: begin
                status <= ST_ERASED;
                ln2_pend <= 1'b1; ln2_addr <= cur[IDX_W-1:0]; ln2_data <= free_head;
                free_head <= cur; count <= count - CNT_W'(1);
              end
              default: status <= ST_MISSING;
            endcase
            state <= S_DONE;
          end
        end
        S_FREE: begin
          // rd_link holds link of free_head (read issued in S_CMP)
          free_head <= rd_link; count <= count + CNT_W'(1); status <= ST_NEW;
          ln2_pend <= 1'b1; ln2_addr <= free_head[IDX_W-1:0]; ln2_data <= NIL;
          state <= S_DONE;
        end
        S_DONE: begin
          ln2_pend <= 1'b0; done <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign lw_en   = ln_we || (state == S_DONE && ln2_pend);
  assign lw_addr = (state == S_DONE) ? ln2_addr : ln_addr;
  assign lw_data = (state == S_DONE) ? ln2_data : ln_data;

  assign busy = state != S_IDLE || done;
endmodule
`default_nettype wire

// ----- design/chained_hash_table.sv -----
// chained_hash_table: top level; request/result channels around the sequencer.
// Depends on cht_pkg, cht_ctrl.
//
// channel | signals                         | role
// in      | in_valid, in_stall, opcode/key/value | request beat
// out     | out_valid, out_stall, status/found_value/entry_total | result beat
//
// The result beat follows the request beat after the head read, the walk
// along the chain and, when an insert links a new node, the S_FREE step;
// the walk is set by the single read port of the node store.
// The next request is taken in the cycle after the result beat leaves.
// Reset empties all chains at once.
// in_stall is high while a request is in work or its result awaits out_stall.
`default_nettype none
module chained_hash_table (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic [31:0] key,
  input  wire logic [31:0] value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic [31:0]      found_value,
  output logic [7:0]       entry_total
);
  import cht_pkg::*;
  logic busy, done, go;
  logic [2:0] st;
  logic [VALUE_BITS-1:0] fv;
  logic [CNT_W-1:0] cnt;

  assign in_stall = busy || out_valid;
  assign go = in_valid && !in_stall;

  cht_ctrl u_ctrl (
    .clk, .rst, .go, .opcode, .key(key[KEY_BITS-1:0]), .value(value[VALUE_BITS-1:0]),
    .busy, .done, .status(st), .found_value(fv), .count(cnt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (done) begin
      status <= st; found_value <= 32'(fv); entry_total <= 8'(cnt);
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("accept while result pending");
  a_done_gap: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("back to back done");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_total <= 8'(ENTRIES)) else $error("count overflow");
endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// tb_top: self-checking testbench for chained_hash_table.
// Depends on cht_pkg and the chained_hash_table RTL; a local predictor checks each result beat.
`timescale 1ns / 1ps
module tb_top;
  import cht_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode = '0;
  logic [31:0] key = '0;
  logic [31:0] value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [31:0] found_value;
  logic [7:0]  entry_total;

  chained_hash_table dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .key(key), .value(value), .out_valid(out_valid),
    .out_stall(out_stall), .status(status), .found_value(found_value),
    .entry_total(entry_total)
  );

  typedef struct packed {
    status_t     st;
    logic [31:0] fv;
    logic [7:0]  total;
  } answer_t;

  // predictor state: mirrors the node pool and chains
  int unsigned head_of[BUCKETS];
  logic [31:0] pool_key[ENTRIES];
  logic [31:0] pool_val[ENTRIES];
  int unsigned pool_next[ENTRIES];
  int unsigned free_ptr;
  int unsigned live;

  answer_t     pending[$];
  logic [31:0] key_set[$];
  int          mismatches = 0;
  bit          quiet = 1'b0;
  int          sent = 0;

  initial forever #5 clk = ~clk;

  function automatic void table_clear();
    for (int i = 0; i < BUCKETS; i++) head_of[i] = ENTRIES;
    for (int i = 0; i < ENTRIES; i++) begin
      pool_key[i] = '0;
      pool_val[i] = '0;
      pool_next[i] = i + 1;
    end
    free_ptr = 0;
    live = 0;
  endfunction

  function automatic answer_t table_apply(logic [1:0] op, logic [31:0] k, logic [31:0] v);
    answer_t     a;
    int unsigned b;
    int unsigned cur;
    int unsigned prev;
    int unsigned steps;
    int unsigned n;
    bit          hit;
    b = k % BUCKETS;
    cur = head_of[b];
    prev = ENTRIES;
    steps = 0;
    a.st = ST_MISSING;
    a.fv = '0;
    while (cur < ENTRIES && steps < ENTRIES && pool_key[cur] != k) begin
      prev = cur;
      cur = pool_next[cur];
      steps++;
    end
    hit = cur < ENTRIES && pool_key[cur] == k;
    case (op)
      OP_INSERT: begin
        if (hit) begin
          pool_val[cur] = v;
          a.st = ST_UPDATED;
        end else if (free_ptr >= ENTRIES) begin
          a.st = ST_FULL;
        end else begin
          n = free_ptr;
          free_ptr = pool_next[n];
          pool_key[n] = k;
          pool_val[n] = v;
          pool_next[n] = ENTRIES;
          if (prev < ENTRIES) pool_next[prev] = n;
          else head_of[b] = n;
          live++;
          a.st = ST_NEW;
        end
      end
      OP_FIND: begin
        if (hit) begin
          a.st = ST_FOUND;
          a.fv = pool_val[cur];
        end
      end
      OP_ERASE: begin
        if (hit) begin
          if (prev < ENTRIES) pool_next[prev] = pool_next[cur];
          else head_of[b] = pool_next[cur];
          pool_next[cur] = free_ptr;
          free_ptr = cur;
          if (live > 0) live--;
          a.st = ST_ERASED;
        end
      end
      default: ;
    endcase
    a.total = live[7:0];
    return a;
  endfunction

  // in_valid stays up between back-to-back beats and drops only for an idle gap
  task automatic send_request(logic [1:0] op, logic [31:0] k, logic [31:0] v);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    key <= k;
    value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending.push_back(table_apply(op, k, v));
    sent++;
  endtask

  // result beats
  always @(posedge clk) begin
    answer_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: status %0d", status);
      end else begin
        want = pending.pop_front();
        if (status !== want.st || found_value !== want.fv || entry_total !== want.total) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st %0d fv %h tot %0d, got st %0d fv %h tot %0d",
                     want.st, want.fv, want.total, status, found_value, entry_total);
        end
      end
    end
  end

  // receiver back-pressure in bursts
  initial begin
    int burst;
    @(negedge rst);
    forever begin
      if (!quiet && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 14);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
    end
  end

  function automatic logic [31:0] pick_key();
    if (key_set.size() > 0 && $urandom_range(0, 3) != 0)
      return key_set[$urandom_range(0, key_set.size() - 1)];
    return $urandom();
  endfunction

  task automatic test_directed();
    send_request(OP_FIND, 32'h0, 32'h0);
    send_request(OP_ERASE, 32'hFFFF_FFFF, 32'h0);
    send_request(OP_INSERT, 32'h0, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h0);
    send_request(OP_INSERT, 32'h40, 32'hA5A5_5A5A);   // same bucket as key 0
    send_request(OP_INSERT, 32'h80, 32'h5A5A_A5A5);
    send_request(OP_FIND, 32'h40, 32'h0);
    send_request(OP_INSERT, 32'h40, 32'h1234_5678);   // overwrite mid-chain
    send_request(OP_FIND, 32'h40, 32'hFFFF_FFFF);
    send_request(OP_UNUSED, 32'h40, 32'h0);
    send_request(OP_ERASE, 32'h40, 32'h0);
    send_request(OP_FIND, 32'h80, 32'h0);
    send_request(OP_FIND, 32'h40, 32'h0);
    send_request(OP_ERASE, 32'h0, 32'h0);
    send_request(OP_FIND, 32'hFFFF_FFFF, 32'h0);
    send_request(OP_ERASE, 32'h80, 32'h0);
    send_request(OP_ERASE, 32'hFFFF_FFFF, 32'h0);
  endtask

  // fill the pool through one long chain, hit table full, then drain
  task automatic test_full_pool();
    for (int i = 0; i <= ENTRIES; i++)
      send_request(OP_INSERT, 32'h7 + 32'(i) * BUCKETS, $urandom());
    send_request(OP_INSERT, 32'h1, 32'h0);
    send_request(OP_INSERT, 32'h7 + 32'(ENTRIES - 1) * BUCKETS, 32'hDEAD_BEEF);
    send_request(OP_FIND, 32'h7 + 32'(ENTRIES - 1) * BUCKETS, 32'h0);
    for (int i = ENTRIES - 1; i >= 0; i--)
      send_request(OP_ERASE, 32'h7 + 32'(i) * BUCKETS, 32'h0);
  endtask

  task automatic test_random(int count);
    logic [31:0] k;
    logic [1:0]  op;
    int          r;
    for (int i = 0; i < count; i++) begin
      if (i == count - 150) quiet = 1'b1;
      r = $urandom_range(0, 99);
      op = r < 45 ? OP_INSERT : r < 75 ? OP_FIND : r < 97 ? OP_ERASE : OP_UNUSED;
      k = pick_key();
      if (op == OP_INSERT && key_set.size() < 400) key_set.push_back(k);
      send_request(op, k, $urandom());
    end
  endtask

  initial begin
    table_clear();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_pool();
    test_random(925);
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
